FILE: rtl/core/fdt_pkg.sv
package fdt_pkg;

    localparam int FDT_INT_BITS      = 32;
    localparam int FDT_FRAC_BITS     = 32;
    localparam int FDT_MAX_PRECISION = 40;
    localparam int FDT_PORT_BITS     = 32;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_INTD,
        ST_POINT,
        ST_FRAC
    } fdt_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic shift_digit;
    } fdt_bcd_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } fdt_frac_ctrl_t;

    function automatic int num_dec_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

endpackage

FILE: rtl/core/fixed_to_decimal_text.sv
// The low min(INT_BITS,32) bits of the integer part are shifted bit by bit through the
//   double-dabble unit, then leading zero digits are skipped (at most 9 for 32-bit integers).
// Throughput: one character per cycle after that, held while out_stall is high; a new
//   item is accepted only once the last character has entered the output register.
// The double-dabble shift unit and the times-ten fraction unit produce the digits.
// Reset: rst_n asynchronous, active low, clears the sequencer and output valid.
module fixed_to_decimal_text
    import fdt_pkg::*;
#(
    parameter int INT_BITS      = FDT_INT_BITS,
    parameter int FRAC_BITS     = FDT_FRAC_BITS,
    parameter int MAX_PRECISION = FDT_MAX_PRECISION
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        is_negative,
    input  logic [31:0] int_magnitude,
    input  logic [31:0] fraction,
    input  logic [5:0]  digits_after_point,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  character,
    output logic        last_char
);

    localparam int IW   = (INT_BITS < FDT_PORT_BITS) ? INT_BITS : FDT_PORT_BITS;
    localparam int NDIG = num_dec_digits(IW);
    localparam int CW   = $clog2(IW + 1);
    localparam int DW   = $clog2(NDIG + 1);
    localparam int PW   = $clog2(MAX_PRECISION + 1);

    fdt_state_t state_reg, state_next;
    logic [CW-1:0] conv_cnt_reg, conv_cnt_next;
    logic [DW-1:0] dcnt_reg, dcnt_next;
    logic [PW-1:0] fcnt_reg, fcnt_next;
    logic [PW-1:0] prec_reg, prec_next;
    logic          neg_reg, neg_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;

    logic [63:0]          int_wide;
    logic [63:0]          frac_wide;
    logic [IW-1:0]        int_in;
    logic [FRAC_BITS-1:0] frac_in;
    logic [5:0]           prec_sat;
    logic                 accept;
    logic                 can_emit;
    logic                 emit;
    logic [3:0]           int_digit;
    logic [3:0]           frac_digit;
    fdt_bcd_ctrl_t        bcd_ctrl;
    fdt_frac_ctrl_t       frac_ctrl;

    assign int_wide  = {32'd0, int_magnitude};
    assign frac_wide = {32'd0, fraction};
    assign int_in    = int_wide[IW-1:0];
    assign frac_in   = frac_wide[FRAC_BITS-1:0];
    assign prec_sat  = (digits_after_point > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                                : digits_after_point;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign can_emit  = !out_valid_reg || !out_stall;

    fdt_bin2bcd #(
        .IW   (IW),
        .NDIG (NDIG)
    ) u_bcd (
        .clk        (clk),
        .ctrl       (bcd_ctrl),
        .load_value (int_in),
        .top_digit  (int_digit)
    );

    fdt_mul10 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul10 (
        .clk        (clk),
        .ctrl       (frac_ctrl),
        .load_value (frac_in),
        .digit      (frac_digit)
    );

    always_comb
    begin
        state_next     = state_reg;
        conv_cnt_next  = conv_cnt_reg;
        dcnt_next      = dcnt_reg;
        fcnt_next      = fcnt_reg;
        prec_next      = prec_reg;
        neg_next       = neg_reg;
        emit           = 1'b0;
        char_next      = char_reg;
        last_next      = last_reg;
        bcd_ctrl       = '0;
        frac_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bcd_ctrl.load  = 1'b1;
                    frac_ctrl.load = 1'b1;
                    neg_next       = is_negative && ((|int_in) || (|frac_in));
                    prec_next      = PW'(prec_sat);
                    conv_cnt_next  = CW'(IW);
                    state_next     = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                bcd_ctrl.step = 1'b1;
                conv_cnt_next = conv_cnt_reg - CW'(1);
                if (conv_cnt_reg == CW'(1))
                begin
                    dcnt_next  = DW'(NDIG);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (int_digit == 4'd0 && dcnt_reg > DW'(1))
                begin
                    bcd_ctrl.shift_digit = 1'b1;
                    dcnt_next            = dcnt_reg - DW'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_INTD;
                end
            end
            ST_SIGN:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    char_next  = CH_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_INTD;
                end
            end
            ST_INTD:
            begin
                if (can_emit)
                begin
                    emit                 = 1'b1;
                    char_next            = CH_ZERO + {4'd0, int_digit};
                    bcd_ctrl.shift_digit = 1'b1;
                    dcnt_next            = dcnt_reg - DW'(1);
                    last_next            = (dcnt_reg == DW'(1)) && (prec_reg == '0);
                    if (dcnt_reg == DW'(1))
                    begin
                        state_next = (prec_reg == '0) ? ST_IDLE : ST_POINT;
                    end
                end
            end
            ST_POINT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    char_next  = CH_POINT;
                    last_next  = 1'b0;
                    fcnt_next  = prec_reg;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    char_next      = CH_ZERO + {4'd0, frac_digit};
                    frac_ctrl.step = 1'b1;
                    fcnt_next      = fcnt_reg - PW'(1);
                    last_next      = (fcnt_reg == PW'(1));
                    if (fcnt_reg == PW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            conv_cnt_reg  <= '0;
            dcnt_reg      <= '0;
            fcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            conv_cnt_reg  <= conv_cnt_next;
            dcnt_reg      <= dcnt_next;
            fcnt_reg      <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prec_reg <= prec_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    a_accept_starts_convert: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CONVERT)
        else $error("transfer did not start conversion");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_next) |=> (state_reg == ST_IDLE && out_valid && last_char))
        else $error("final character did not end the item");

    a_intd_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INTD |-> dcnt_reg != '0)
        else $error("integer digit count underflow");

    a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FRAC |-> fcnt_reg != '0)
        else $error("fraction digit count underflow");

endmodule

FILE: rtl/core/fdt_bin2bcd.sv
module fdt_bin2bcd
    import fdt_pkg::*;
#(
    parameter int IW   = FDT_PORT_BITS,
    parameter int NDIG = num_dec_digits(FDT_PORT_BITS)
)
(
    input  logic          clk,
    input  fdt_bcd_ctrl_t ctrl,
    input  logic [IW-1:0] load_value,
    output logic [3:0]    top_digit
);

    localparam int BW = NDIG * 4;

    logic [IW-1:0] bin_reg;
    logic [IW-1:0] bin_next;
    logic [BW-1:0] bcd_reg;
    logic [BW-1:0] bcd_next;
    logic [BW-1:0] adj;

    always_comb
    begin
        adj = bcd_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = load_value;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            bcd_next = {adj[BW-2:0], bin_reg[IW-1]};
            bin_next = {bin_reg[IW-2:0], 1'b0};
        end
        else if (ctrl.shift_digit)
        begin
            bcd_next = {bcd_reg[BW-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BW-1 -: 4];

endmodule

FILE: rtl/core/fdt_mul10.sv
module fdt_mul10
    import fdt_pkg::*;
#(
    parameter int FRAC_BITS = FDT_FRAC_BITS
)
(
    input  logic                 clk,
    input  fdt_frac_ctrl_t       ctrl,
    input  logic [FRAC_BITS-1:0] load_value,
    output logic [3:0]           digit
);

    logic [FRAC_BITS-1:0] frac_reg;
    logic [FRAC_BITS-1:0] frac_next;
    logic [FRAC_BITS+3:0] prod;

    assign prod  = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1);
    assign digit = prod[FRAC_BITS+3:FRAC_BITS];

    always_comb
    begin
        frac_next = frac_reg;
        if (ctrl.load)
        begin
            frac_next = load_value;
        end
        else if (ctrl.step)
        begin
            frac_next = prod[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
    end

endmodule

FILE: dv/fixed_to_decimal_text_tb.sv
module fixed_to_decimal_text_tb
    import fdt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk;
    logic        rst_n              = 1'b0;
    logic        in_valid           = 1'b0;
    logic        in_stall;
    logic        is_negative        = 1'b0;
    logic [31:0] int_magnitude      = '0;
    logic [31:0] fraction           = '0;
    logic [5:0]  digits_after_point = '0;
    logic        out_valid;
    logic        out_stall          = 1'b0;
    logic [7:0]  character;
    logic        last_char;

    text_char_t expected_chars[$];
    int         mismatches    = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_request  = 0;

    fixed_to_decimal_text DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .is_negative        (is_negative),
        .int_magnitude      (int_magnitude),
        .fraction           (fraction),
        .digits_after_point (digits_after_point),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .character          (character),
        .last_char          (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("** fixed_to_decimal_text: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < 40)
            $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Build the text of one number and queue its characters.
    function automatic void predict_text(input logic neg, input logic [31:0] mag,
                                         input logic [31:0] frac, input logic [5:0] nd);
        text_char_t  txt[$];
        logic [7:0]  digs[$];
        logic [31:0] v;
        logic [31:0] f;
        logic [35:0] prod;
        int          prec;
        v = mag;
        f = frac;
        prec = (nd > FDT_MAX_PRECISION) ? FDT_MAX_PRECISION : int'(nd);
        if (neg && (mag != 0 || frac != 0))
            txt.push_back(text_char_t'{CH_MINUS, 1'b0});
        do
        begin
            digs.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digs[i])
            txt.push_back(text_char_t'{digs[i], 1'b0});
        if (prec > 0)
        begin
            txt.push_back(text_char_t'{CH_POINT, 1'b0});
            for (int i = 0; i < prec; i++)
            begin
                prod = {4'b0, f} * 36'd10;
                txt.push_back(text_char_t'{CH_ZERO + 8'(prod[35:32]), 1'b0});
                f = prod[31:0];
            end
        end
        txt[txt.size() - 1].last = 1'b1;
        foreach (txt[i])
            expected_chars.push_back(txt[i]);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_number(input logic neg, input logic [31:0] mag,
                               input logic [31:0] frac, input logic [5:0] nd);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid           <= 1'b1;
        is_negative        <= neg;
        int_magnitude      <= mag;
        fraction           <= frac;
        digits_after_point <= nd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_text(neg, mag, frac, nd);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_number();
        logic        neg;
        logic [31:0] mag;
        logic [31:0] frac;
        logic [5:0]  nd;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       mag = '0;
            1:       mag = $urandom_range(0, 9);
            2:       mag = $urandom_range(0, 99999);
            3:       mag = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: mag = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       frac = '0;
            1:       frac = 32'hFFFF_FFFF;
            2:       frac = $urandom >> $urandom_range(0, 31);
            default: frac = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       nd = '0;
            1:       nd = 6'($urandom_range(FDT_MAX_PRECISION + 1, 63));
            2:       nd = 6'(FDT_MAX_PRECISION);
            default: nd = 6'($urandom_range(1, FDT_MAX_PRECISION));
        endcase
        send_number(neg, mag, frac, nd);
    endtask

    task automatic test_directed();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        send_number(1'b0, 32'd0, 32'd0, 6'd0);
        send_number(1'b1, 32'd0, 32'd0, 6'd5);
        send_number(1'b1, 32'd0, 32'h8000_0000, 6'd3);
        send_number(1'b1, 32'd0, 32'd1, 6'd40);
        send_number(1'b0, 32'd0, 32'd1, 6'd32);
        send_number(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd40);
        send_number(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_number(1'b0, 32'd1, 32'd0, 6'd41);
        send_number(1'b0, 32'd10, 32'h1999_999A, 6'd1);
        send_number(1'b0, 32'd1_000_000_000, 32'd1, 6'd40);
        send_number(1'b1, 32'd999_999_999, 32'hFFFF_FFFF, 6'd0);
        send_number(1'b0, 32'hFFFF_FFFF, 32'd0, 6'd0);
        send_number(1'b0, 32'd9, 32'h5555_5555, 6'd42);
        send_number(1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 6'd21);
        send_number(1'b0, 32'h5555_5555, 32'h5555_5555, 6'd1);
        send_number(1'b1, 32'd7, 32'd0, 6'd2);
        send_number(1'b0, 32'd123_456_789, 32'h1234_5678, 6'd12);
        send_number(1'b1, 32'd1, 32'hFFFF_FFFF, 6'd63);
        drain_results();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
            send_random_number();
        drain_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_request = 600;
        @(negedge clk);
        repeat (6)
            send_random_number();
        drain_results();
    endtask

    // Receiver: random stall, or a long hold-off when requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_chars
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("character transfer with nothing expected", character, 8'h00);
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.ch)
                    report_mismatch("character", character, want.ch);
                if (last_char !== want.last)
                    report_mismatch("last_char", {7'b0, last_char}, {7'b0, want.last});
            end
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(85, 25, 59);
        test_random(85, 59, 25);
        test_random(80, 0, 0);
        test_backpressure();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("** fixed_to_decimal_text: PASSED **");
        else
            $display("** fixed_to_decimal_text: FAILED **");
        $finish;
    end

endmodule
